// ===== sv/wtq_pkg.sv =====
package wtq_pkg;

    // Field widths fixed by the item format.
    localparam int LEN_W       = 7;
    localparam int BYTES_W     = 8;
    localparam int BITS_W      = 64;
    localparam int TICK_W      = 20;
    localparam int CFG_INDEX_W = 8;
    localparam int BYTES_MAX   = BITS_W / 8;

    // Queue depth default; one slot always stays empty.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Longest message that is accepted.
    localparam logic [LEN_W-1:0] MAX_BITS = 7'd64;

    // Timing register reset values.
    localparam logic [TICK_W-1:0] PULSE_TICKS_RST     = 20'd100;
    localparam logic [TICK_W-1:0] GAP_TICKS_RST       = 20'd1000;
    localparam logic [TICK_W-1:0] MSG_GAP_TICKS_RST   = 20'd20000;
    localparam logic [TICK_W-1:0] IDLE_POLL_TICKS_RST = 20'd2000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_TICKS     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TICKS       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MSG_GAP_TICKS   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_POLL_TICKS = 8'd3;

    // Item operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [2:0] {
        WS_NONE          = 3'd0,
        WS_QUEUED        = 3'd1,
        WS_TOO_MANY_BITS = 3'd2,
        WS_TOO_FEW_BYTES = 3'd3,
        WS_QUEUE_FULL    = 3'd4
    } write_status_t;

    typedef struct packed {
        logic [TICK_W-1:0] pulse;
        logic [TICK_W-1:0] gap;
        logic [TICK_W-1:0] msg_gap;
        logic [TICK_W-1:0] idle_poll;
    } timing_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BITS_W-1:0] wr_bits;
        logic [LEN_W-1:0]  wr_len;
    } queue_req_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [BITS_W-1:0] rd_bits;
        logic [LEN_W-1:0]  rd_len;
    } queue_status_t;

    typedef struct packed {
        logic          d0;
        logic          d1;
        write_status_t status;
        logic          sending;
    } result_t;

endpackage

// ===== sv/wtq_queue.sv =====
module wtq_queue
    import wtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_req_t    req,
    output queue_status_t status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int ENT_W = BITS_W + LEN_W;

    logic [ENT_W-1:0] mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] rd_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_next;
    logic [ENT_W-1:0] wr_data;

    // Pointer increment with wrap at the queue depth.
    assign head_inc  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_next = req.push ? head_inc : head_reg;
    assign tail_next = req.pop  ? tail_inc : tail_reg;
    assign wr_data   = {req.wr_bits, req.wr_len};

    // Pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Storage; the read port always holds the entry at the next tail, and a
    // write to that same entry is forwarded.
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[head_reg] <= wr_data;
        end
        if (req.push && (head_reg == tail_next))
        begin
            rd_reg <= wr_data;
        end
        else
        begin
            rd_reg <= mem[tail_next];
        end
    end

    assign status.empty   = (head_reg == tail_reg);
    assign status.full    = (head_inc == tail_reg);
    assign status.rd_bits = rd_reg[ENT_W-1:LEN_W];
    assign status.rd_len  = rd_reg[LEN_W-1:0];

    // A message is never taken from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) req.pop |-> !status.empty)
        else $error("queue popped while empty");

    // A message is never placed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) req.push |-> !status.full)
        else $error("queue pushed while full");

    // A transfer into the queue leaves it non-empty.
    assert property (@(posedge clk) disable iff (!rst_n) req.push |=> !status.empty)
        else $error("queue empty after push");

    // Writes and ticks are separate items, so push and pop never coincide.
    assert property (@(posedge clk) disable iff (!rst_n) !(req.push && req.pop))
        else $error("push and pop in the same cycle");

endmodule

// ===== sv/wtq_core.sv =====
module wtq_core
    import wtq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_en,
    input  logic               op,
    input  logic [LEN_W-1:0]   bit_count,
    input  logic [BYTES_W-1:0] byte_count,
    input  logic [BITS_W-1:0]  payload,
    input  timing_t            timing,
    input  queue_status_t      q_status,
    output queue_req_t         q_req,
    output result_t            result
);

    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              pulse_reg, pulse_next;
    logic              one_reg, one_next;
    logic [TICK_W-1:0] cnt_reg, cnt_next;
    write_status_t     status;
    logic [BITS_W-1:0] masked;

    // Bytes at or beyond the byte count are taken as zero.
    always_comb
    begin
        for (int i = 0; i < BYTES_MAX; i++)
        begin
            masked[i*8 +: 8] = (byte_count > BYTES_W'(i)) ? payload[i*8 +: 8] : 8'h00;
        end
    end

    // Write checks.
    always_comb
    begin
        if (bit_count > MAX_BITS)
        begin
            status = WS_TOO_MANY_BITS;
        end
        else if (BYTES_W'(bit_count >> 3) > byte_count)
        begin
            status = WS_TOO_FEW_BYTES;
        end
        else if (q_status.full)
        begin
            status = WS_QUEUE_FULL;
        end
        else
        begin
            status = WS_QUEUED;
        end
    end

    // Queued writes push; ticks count down, then step the transmitter.
    always_comb
    begin
        logic [BITS_W-1:0] cur_bits;
        logic [LEN_W-1:0]  cur_len;
        logic [LEN_W-1:0]  cur_pos;
        logic [LEN_W-1:0]  pos_inc;

        bits_next     = bits_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        pulse_next    = pulse_reg;
        one_next      = one_reg;
        cnt_next      = cnt_reg;
        q_req.push    = 1'b0;
        q_req.pop     = 1'b0;
        q_req.wr_bits = masked;
        q_req.wr_len  = bit_count;
        cur_bits      = bits_reg;
        cur_len       = len_reg;
        cur_pos       = pos_reg;
        pos_inc       = pos_reg + 1'b1;

        if (item_en && (op == OP_WRITE))
        begin
            q_req.push = (status == WS_QUEUED);
        end
        else if (item_en && (cnt_reg > TICK_W'(1)))
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else if (item_en)
        begin
            if ((len_reg == '0) && q_status.empty)
            begin
                // Idle with nothing queued: poll again later.
                cnt_next = timing.idle_poll;
            end
            else if ((len_reg == '0) && (q_status.rd_len == '0))
            begin
                // Zero-bit message is taken out and dropped.
                q_req.pop = 1'b1;
                bits_next = q_status.rd_bits;
                pos_next  = '0;
                cnt_next  = timing.idle_poll;
            end
            else if (pulse_reg)
            begin
                // End of a pulse: either a gap or the end of the message.
                pulse_next = 1'b0;
                if (pos_inc >= len_reg)
                begin
                    pos_next = '0;
                    len_next = '0;
                    cnt_next = timing.msg_gap;
                end
                else
                begin
                    pos_next = pos_inc;
                    cnt_next = timing.gap;
                end
            end
            else
            begin
                // Start a pulse, loading a new message first when idle.
                if (len_reg == '0)
                begin
                    q_req.pop = 1'b1;
                    cur_bits  = q_status.rd_bits;
                    cur_len   = q_status.rd_len;
                    cur_pos   = '0;
                end
                bits_next  = cur_bits;
                len_next   = cur_len;
                pos_next   = cur_pos;
                one_next   = cur_bits[cur_pos[5:0]];
                pulse_next = 1'b1;
                cnt_next   = timing.pulse;
            end
        end
    end

    // Transmitter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            pulse_reg <= 1'b0;
            one_reg   <= 1'b0;
            cnt_reg   <= TICK_W'(1);
        end
        else
        begin
            bits_reg  <= bits_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            pulse_reg <= pulse_next;
            one_reg   <= one_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Line levels and status after this item.
    assign result.d0      = !(pulse_next && !one_next);
    assign result.d1      = !(pulse_next && one_next);
    assign result.status  = (op == OP_WRITE) ? status : WS_NONE;
    assign result.sending = (len_next != '0);

endmodule

// ===== sv/wiegand_transmitter_with_queue.sv =====
// A result is registered: the input register takes the item at the transfer, and the result
// register takes its result when the item moves on, which a stalled output can delay.
// Throughput: one item per cycle while the output is not stalled; the transmitter step and
// the write checks are both combinational between the two registers.
// Reset (rst_n, asynchronous, active low) empties the queue, stops any message,
// restores the timing registers and arms the countdown to fire on the first tick.
module wiegand_transmitter_with_queue
    import wtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [LEN_W-1:0]       bit_count,
    input  logic [BYTES_W-1:0]     byte_count,
    input  logic [BITS_W-1:0]      payload,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   d0_level,
    output logic                   d1_level,
    output logic [2:0]             write_status,
    output logic                   sending,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data
);

    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic [LEN_W-1:0]   s1_bits_reg;
    logic [BYTES_W-1:0] s1_bytes_reg;
    logic [BITS_W-1:0]  s1_payload_reg;
    logic               advance;
    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result;
    timing_t            timing_reg;
    queue_req_t         q_req;
    queue_status_t      q_status;

    // The item in the input register moves on when the result register is free.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_op_reg      <= op;
            s1_bits_reg    <= bit_count;
            s1_bytes_reg   <= byte_count;
            s1_payload_reg <= payload;
        end
    end

    // Timing registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.pulse     <= PULSE_TICKS_RST;
            timing_reg.gap       <= GAP_TICKS_RST;
            timing_reg.msg_gap   <= MSG_GAP_TICKS_RST;
            timing_reg.idle_poll <= IDLE_POLL_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PULSE_TICKS:     timing_reg.pulse     <= cfg_data;
                CFG_GAP_TICKS:       timing_reg.gap       <= cfg_data;
                CFG_MSG_GAP_TICKS:   timing_reg.msg_gap   <= cfg_data;
                CFG_IDLE_POLL_TICKS: timing_reg.idle_poll <= cfg_data;
                default:             ;
            endcase
        end
    end

    wtq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (q_req),
        .status (q_status)
    );

    wtq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_en    (advance),
        .op         (s1_op_reg),
        .bit_count  (s1_bits_reg),
        .byte_count (s1_bytes_reg),
        .payload    (s1_payload_reg),
        .timing     (timing_reg),
        .q_status   (q_status),
        .q_req      (q_req),
        .result     (result)
    );

    // Result register; it holds while the output transfer is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign d0_level     = result_reg.d0;
    assign d1_level     = result_reg.d1;
    assign write_status = result_reg.status;
    assign sending      = result_reg.sending;

endmodule
